// ----- rtl/ffla_pkg.sv -----
// ----------------------------------------------------------------------------
// ffla_pkg
// Shared types and constants of the frame free list allocator.
// ----------------------------------------------------------------------------
package ffla_pkg;

  localparam int MAX_FRAMES = 4096;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);   // frame address into table
  localparam int CNT_W      = FRAME_W + 1;          // link / frame count width

  // port field widths
  localparam int CFG_W      = 13;
  localparam int OP_W       = 2;
  localparam int PCNT_W     = 8;
  localparam int IDX_W      = 12;
  localparam int STATUS_W   = 3;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [CFG_W-1:0]  TOTAL_RESET = CFG_W'(4096);
  localparam logic [CFG_W-1:0]  RSVD_RESET  = '0;
  localparam logic [PCNT_W-1:0] ONE_PAGE    = PCNT_W'(1);

  // top bit set marks the end of the list
  localparam logic [CNT_W-1:0]  NULL_LINK   = {1'b1, {FRAME_W{1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_BAD_COUNT = 3'd2,
    ST_IGNORED   = 3'd3,
    ST_NO_INIT   = 3'd4
  } status_e;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_TOTAL    = 1'b0,
    REG_RESERVED = 1'b1
  } reg_e;

  // one table entry: used bit and successor link
  typedef struct packed {
    logic             used;
    logic [CNT_W-1:0] link;
  } entry_t;

endpackage

// ----- rtl/frame_free_list_allocator_unit.sv -----
// Allocate and free are taken in idle, read the table entry into rdata_q, and answer
// from the read state; every other request, failures included, answers in the cycle
// after it is taken, but for an init of a nonzero total, which rewrites the table one
// entry a cycle in the init state. No request is taken outside idle or over a stalled result.
// Reset clears control state only; the table holds garbage until an init runs.
// ----------------------------------------------------------------------------
// frame_free_list_allocator_unit
// Single-page frame allocator on a linked free list held in one table RAM.
// ----------------------------------------------------------------------------
module frame_free_list_allocator_unit
  import ffla_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  // request
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OP_W-1:0]     opcode_i,
  input  logic [PCNT_W-1:0]   page_count_i,
  input  logic [IDX_W-1:0]    frame_index_i,
  // result
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [IDX_W-1:0]    frame_index_res_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_INIT = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [CFG_W-1:0]     total_cfg_q, rsvd_cfg_q;
  logic [CNT_W-1:0]     tot_q, tot_d;
  logic [CNT_W-1:0]     rsvd_q, rsvd_d;
  logic [CNT_W-1:0]     head_q, head_d;
  logic                 init_q, init_d;
  logic                 alloc_q, alloc_d;
  logic [FRAME_W-1:0]   addr_q, addr_d;
  logic [FRAME_W-1:0]   cnt_q, cnt_d;
  logic                 out_valid_q;
  status_e              status_q;
  logic [IDX_W-1:0]     fres_q;

  entry_t               mem_q [MAX_FRAMES];
  entry_t               rdata_q;
  logic                 mem_we;
  logic [FRAME_W-1:0]   mem_waddr;
  logic [FRAME_W-1:0]   mem_raddr;
  entry_t               mem_wdata;

  logic                 accept;
  logic                 out_set;
  status_e              st_new;
  logic [IDX_W-1:0]     fres_new;
  logic [CNT_W-1:0]     tot_n, rsvd_n;
  logic [CNT_W-1:0]     cnt_nxt;
  logic                 cfg_wr;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_cfg_q <= TOTAL_RESET;
      rsvd_cfg_q  <= RSVD_RESET;
    end else if (cfg_wr) begin
      unique case (reg_e'(paddr[2]))
        REG_TOTAL:    total_cfg_q <= pwdata[CFG_W-1:0];
        REG_RESERVED: rsvd_cfg_q  <= pwdata[CFG_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (reg_e'(paddr[2]))
        REG_TOTAL:    prdata = APB_DW'(total_cfg_q);
        REG_RESERVED: prdata = APB_DW'(rsvd_cfg_q);
        default:      prdata = '0;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // table RAM
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  // --------------------------------------------------------------------------
  // control
  // --------------------------------------------------------------------------
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // clamp total to the table size, reserved to the total
  assign tot_n   = (32'(total_cfg_q) > 32'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES)
                                                        : CNT_W'(total_cfg_q);
  assign rsvd_n  = (32'(rsvd_cfg_q) > 32'(tot_n)) ? tot_n : CNT_W'(rsvd_cfg_q);
  assign cnt_nxt = CNT_W'(cnt_q) + CNT_W'(1);

  always_comb begin
    state_d   = state_q;
    tot_d     = tot_q;
    rsvd_d    = rsvd_q;
    head_d    = head_q;
    init_d    = init_q;
    alloc_d   = alloc_q;
    addr_d    = addr_q;
    cnt_d     = cnt_q;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_raddr = addr_q;
    mem_wdata = '{used: 1'b1, link: NULL_LINK};
    out_set   = 1'b0;
    st_new    = ST_OK;
    fres_new  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op_e'(opcode_i))
            OP_INIT: begin
              tot_d  = tot_n;
              rsvd_d = rsvd_n;
              init_d = 1'b1;
              head_d = (rsvd_n < tot_n) ? rsvd_n : NULL_LINK;
              cnt_d  = '0;
              if (tot_n == '0) begin
                out_set = 1'b1;
              end else begin
                state_d = S_INIT;
              end
            end
            OP_ALLOC: begin
              if (!init_q) begin
                out_set = 1'b1;
                st_new  = ST_NO_INIT;
              end else if (page_count_i != ONE_PAGE) begin
                out_set = 1'b1;
                st_new  = ST_BAD_COUNT;
              end else if (head_q[CNT_W-1] || head_q >= tot_q) begin
                out_set = 1'b1;
                st_new  = ST_EMPTY;
              end else begin
                alloc_d   = 1'b1;
                addr_d    = head_q[FRAME_W-1:0];
                mem_raddr = head_q[FRAME_W-1:0];
                state_d   = S_READ;
              end
            end
            OP_FREE: begin
              if (!init_q) begin
                out_set = 1'b1;
                st_new  = ST_NO_INIT;
              end else if (32'(frame_index_i) >= 32'(tot_q)) begin
                out_set = 1'b1;
                st_new  = ST_IGNORED;
              end else begin
                alloc_d   = 1'b0;
                addr_d    = FRAME_W'(frame_index_i);
                mem_raddr = FRAME_W'(frame_index_i);
                state_d   = S_READ;
              end
            end
            default: begin
              out_set = 1'b1;
              st_new  = ST_IGNORED;
            end
          endcase
        end
      end
      S_READ: begin
        // entry of the head (alloc) or of the freed frame is in rdata_q
        out_set = 1'b1;
        state_d = S_IDLE;
        if (alloc_q) begin
          mem_we    = 1'b1;
          mem_wdata = '{used: 1'b1, link: NULL_LINK};
          head_d    = rdata_q.link;
          fres_new  = IDX_W'(addr_q);
        end else if (rdata_q.used) begin
          mem_we    = 1'b1;
          mem_wdata = '{used: 1'b0, link: head_q};
          head_d    = CNT_W'(addr_q);
        end else begin
          st_new = ST_IGNORED;
        end
      end
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        if (CNT_W'(cnt_q) < rsvd_q) begin
          mem_wdata = '{used: 1'b1, link: NULL_LINK};
        end else begin
          mem_wdata = '{used: 1'b0, link: (cnt_nxt < tot_q) ? cnt_nxt : NULL_LINK};
        end
        if (cnt_nxt == tot_q) begin
          out_set = 1'b1;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_nxt[FRAME_W-1:0];
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tot_q       <= '0;
      rsvd_q      <= '0;
      head_q      <= NULL_LINK;
      init_q      <= 1'b0;
      alloc_q     <= 1'b0;
      addr_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tot_q   <= tot_d;
      rsvd_q  <= rsvd_d;
      head_q  <= head_d;
      init_q  <= init_d;
      alloc_q <= alloc_d;
      addr_q  <= addr_d;
      cnt_q   <= cnt_d;
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_set) begin
      status_q <= st_new;
      fres_q   <= fres_new;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign frame_index_res_o = fres_q;

endmodule

// ----- rtl/ffla_checker.sv -----
// ----------------------------------------------------------------------------
// ffla_checker
// Port-level checks of the frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffla_checker
  import ffla_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [STATUS_W-1:0] status_o,
  input logic [IDX_W-1:0]    frame_index_res_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
                                    && $stable(frame_index_res_o))
    else $error("result changed while stalled");

  // only one result in flight: no request taken over a stalled result
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("request taken while result stalled");

  // a granted frame only comes with ok status
  a_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> frame_index_res_o == '0)
    else $error("frame index on a failed request");

  // no result without a request behind it
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !(in_valid_i && in_ready_o) |=> !out_valid_o)
    else $error("result without a request");

endmodule

bind frame_free_list_allocator_unit ffla_checker u_ffla_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .status_o          (status_o),
  .frame_index_res_o (frame_index_res_o)
);
